@@ hdl/sfr_pkg.sv @@
package sfr_pkg;

  localparam int unsigned PosW  = 3;
  localparam int unsigned CntW  = 9;
  localparam int unsigned ByteW = 8;

  // Header "IMPROV" followed by the version byte; last entry is padding.
  localparam logic [7:0] HeaderPattern [8] = '{
    8'h49, 8'h4D, 8'h50, 8'h52, 8'h4F, 8'h56, 8'h01, 8'h00
  };

  // Sum of the header bytes, seed of the frame checksum.
  localparam logic [7:0] SumSeed = 8'hDE;

  typedef enum logic [2:0] {
    ROLE_HDR_MATCH    = 3'd0,
    ROLE_HDR_MISMATCH = 3'd1,
    ROLE_TYPE         = 3'd2,
    ROLE_LENGTH       = 3'd3,
    ROLE_DATA         = 3'd4,
    ROLE_CHECKSUM     = 3'd5
  } byte_role_e;

  typedef struct packed {
    logic [7:0] data_byte;
    byte_role_e byte_role;
    logic       frame_done;
    logic       frame_valid;
    logic       frame_overflow;
    logic       session_active;
  } sfr_result_t;

endpackage

@@ hdl/sfr_in_if.sv @@
interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ hdl/sfr_out_if.sv @@
interface sfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [2:0] byte_role;
  logic       frame_done;
  logic       frame_valid;
  logic       frame_overflow;
  logic       session_active;

  modport source (
    output valid, output data_byte, output byte_role, output frame_done,
    output frame_valid, output frame_overflow, output session_active,
    input ready
  );
  modport sink (
    input valid, input data_byte, input byte_role, input frame_done,
    input frame_valid, input frame_overflow, input session_active,
    output ready
  );
endinterface

@@ hdl/sfr_parser.sv @@
module sfr_parser #(
  parameter int unsigned HEADER_BYTES = 7,
  parameter int unsigned MAX_BODY     = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  output sfr_pkg::sfr_result_t result_o
);

  logic [sfr_pkg::PosW-1:0] pos_q, pos_d;
  logic [sfr_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [7:0]               len_q, len_d;
  logic [7:0]               sum_q, sum_d;
  logic                     active_q, active_d;

  logic                     in_body;
  logic                     hdr_match;
  logic [sfr_pkg::CntW:0]   size;
  logic                     is_cksum;

  assign in_body   = pos_q >= sfr_pkg::PosW'(HEADER_BYTES);
  assign hdr_match = byte_i == sfr_pkg::HeaderPattern[pos_q];
  assign size      = {1'b0, cnt_q} + (sfr_pkg::CntW+1)'(1);
  assign is_cksum  = (cnt_q > sfr_pkg::CntW'(1))
                   && (cnt_q == {1'b0, len_q} + sfr_pkg::CntW'(2));

  always_comb begin
    pos_d    = pos_q;
    cnt_d    = cnt_q;
    len_d    = len_q;
    sum_d    = sum_q;
    active_d = active_q;

    result_o.data_byte      = byte_i;
    result_o.byte_role      = sfr_pkg::ROLE_HDR_MATCH;
    result_o.frame_done     = 1'b0;
    result_o.frame_valid    = 1'b0;
    result_o.frame_overflow = 1'b0;

    if (!in_body) begin
      if (hdr_match) begin
        pos_d              = pos_q + sfr_pkg::PosW'(1);
        result_o.byte_role = sfr_pkg::ROLE_HDR_MATCH;
      end else begin
        pos_d              = (byte_i == sfr_pkg::HeaderPattern[0])
                           ? sfr_pkg::PosW'(1) : '0;
        result_o.byte_role = sfr_pkg::ROLE_HDR_MISMATCH;
      end
    end else begin
      if (cnt_q == '0) begin
        result_o.byte_role = sfr_pkg::ROLE_TYPE;
      end else if (cnt_q == sfr_pkg::CntW'(1)) begin
        result_o.byte_role = sfr_pkg::ROLE_LENGTH;
        len_d              = byte_i;
      end else if (is_cksum) begin
        result_o.byte_role = sfr_pkg::ROLE_CHECKSUM;
      end else begin
        result_o.byte_role = sfr_pkg::ROLE_DATA;
      end

      if (is_cksum) begin
        result_o.frame_done  = 1'b1;
        result_o.frame_valid = sum_q == byte_i;
        if (sum_q == byte_i) begin
          active_d = 1'b1;
        end
        pos_d = '0;
        cnt_d = '0;
        sum_d = sfr_pkg::SumSeed;
      end else begin
        sum_d = sum_q + byte_i;
        cnt_d = size[sfr_pkg::CntW-1:0];
        if (size > (sfr_pkg::CntW+1)'(MAX_BODY)) begin
          // body too long without a checksum: drop it and hunt for a header
          result_o.frame_overflow = 1'b1;
          pos_d = '0;
          cnt_d = '0;
          sum_d = sfr_pkg::SumSeed;
        end
      end
    end

    result_o.session_active = active_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      cnt_q    <= '0;
      len_q    <= '0;
      sum_q    <= sfr_pkg::SumSeed;
      active_q <= 1'b0;
    end else if (step_i) begin
      pos_q    <= pos_d;
      cnt_q    <= cnt_d;
      len_q    <= len_d;
      sum_q    <= sum_d;
      active_q <= active_d;
    end
  end

endmodule

@@ hdl/serial_frame_receiver_core.sv @@
// Serial frame receiver: one received byte per request on rx_i, one result
// per byte on res_o. The byte is passed through with its role in the frame
// (header match/mismatch, type, length, data, checksum). Frames are the
// header "IMPROV" + 0x01, then type, length, <length> data bytes and an 8-bit
// checksum equal to 0xDE plus the sum of type, length and data bytes. The
// checksum byte raises frame_done, and frame_valid when it matches; the first
// valid frame sets session_active until reset. A body that grows past
// MAX_BODY bytes without its checksum is dropped and flagged with
// frame_overflow. Throughput is one byte per clock while res_o is not stalled;
// each byte is caught in the input register when accepted, then passes the
// parser into the result register. HEADER_BYTES selects how many leading
// bytes of the header are matched (1..7).
module serial_frame_receiver_core #(
  parameter int unsigned HEADER_BYTES = 7,
  parameter int unsigned MAX_BODY     = 256
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  sfr_in_if.sink    rx_i,
  sfr_out_if.source res_o
);

  // input register
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;

  // result register
  logic                 out_valid_q, out_valid_d;
  sfr_pkg::sfr_result_t out_q;
  sfr_pkg::sfr_result_t result;

  logic advance;
  logic rx_take;

  // the parser step fires when the input register holds a byte and the
  // result register is empty or being drained this cycle
  assign advance    = in_valid_q && (!out_valid_q || res_o.ready);
  assign rx_i.ready = !in_valid_q || advance;
  assign rx_take    = rx_i.valid && rx_i.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (rx_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  sfr_parser #(
    .HEADER_BYTES(HEADER_BYTES),
    .MAX_BODY    (MAX_BODY)
  ) u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .byte_i  (in_byte_q),
    .result_o(result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (rx_take) begin
      in_byte_q <= rx_i.rx_byte;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.data_byte      = out_q.data_byte;
  assign res_o.byte_role      = out_q.byte_role;
  assign res_o.frame_done     = out_q.frame_done;
  assign res_o.frame_valid    = out_q.frame_valid;
  assign res_o.frame_overflow = out_q.frame_overflow;
  assign res_o.session_active = out_q.session_active;

endmodule

@@ tb/sfr_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels, predicts each result from the accepted byte and
// compares it against what the receiver hands out.
module sfr_checker #(
  parameter int unsigned HEADER_BYTES = 7,
  parameter int unsigned MAX_BODY     = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sfr_in_if           rx_i,
  sfr_out_if          res_i,
  output int unsigned mismatches_o,
  output int unsigned outstanding_o
);

  // Predicted parser state.
  logic [sfr_pkg::PosW-1:0]  hdr_pos;
  logic [sfr_pkg::CntW-1:0]  body_cnt;
  logic [sfr_pkg::ByteW-1:0] frame_len;
  logic [sfr_pkg::ByteW-1:0] frame_sum;
  logic                      session_seen;

  sfr_pkg::sfr_result_t byte_results_q[$];
  int unsigned          fail_cnt;

  function automatic void restart_parse();
    hdr_pos   = '0;
    body_cnt  = '0;
    frame_sum = sfr_pkg::SumSeed;
  endfunction

  function automatic sfr_pkg::sfr_result_t parse_rx_byte(input logic [7:0] b);
    sfr_pkg::sfr_result_t r;
    int unsigned          size;
    r           = '0;
    r.data_byte = b;
    if (hdr_pos < HEADER_BYTES) begin
      if (b == sfr_pkg::HeaderPattern[hdr_pos]) begin
        hdr_pos     = hdr_pos + 1'b1;
        r.byte_role = sfr_pkg::ROLE_HDR_MATCH;
      end else begin
        // an 'I' may already start the next header
        hdr_pos     = (b == sfr_pkg::HeaderPattern[0]) ? sfr_pkg::PosW'(1) : '0;
        r.byte_role = sfr_pkg::ROLE_HDR_MISMATCH;
      end
    end else begin
      if (body_cnt == 0) begin
        r.byte_role = sfr_pkg::ROLE_TYPE;
      end else if (body_cnt == 1) begin
        r.byte_role = sfr_pkg::ROLE_LENGTH;
        frame_len   = b;
      end else if (int'(body_cnt) == int'(frame_len) + 2) begin
        r.byte_role = sfr_pkg::ROLE_CHECKSUM;
      end else begin
        r.byte_role = sfr_pkg::ROLE_DATA;
      end
      if (r.byte_role == sfr_pkg::ROLE_CHECKSUM) begin
        r.frame_done  = 1'b1;
        r.frame_valid = (frame_sum == b);
        if (r.frame_valid) session_seen = 1'b1;
        restart_parse();
      end else begin
        frame_sum = frame_sum + b;
        // limit check on the unwrapped count
        size      = int'(body_cnt) + 1;
        body_cnt  = sfr_pkg::CntW'(size);
        if (size > MAX_BODY) begin
          r.frame_overflow = 1'b1;
          restart_parse();
        end
      end
    end
    r.session_active = session_seen;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH %s", $realtime, msg);
    fail_cnt++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want, input logic [7:0] rx_byte);
    if (got !== want)
      report_mismatch($sformatf("%s for byte %0h: got %0h, want %0h",
                                name, rx_byte, got, want));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sfr_pkg::sfr_result_t want;
    sfr_pkg::sfr_result_t pred;
    if (!rst_ni) begin
      restart_parse();
      frame_len     = '0;
      session_seen  = 1'b0;
      byte_results_q.delete();
      fail_cnt      = 0;
      mismatches_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (rx_i.valid && rx_i.ready) begin
        pred           = parse_rx_byte(rx_i.rx_byte);
        byte_results_q = {byte_results_q, pred};
      end
      if (res_i.valid && res_i.ready) begin
        if (byte_results_q.size() == 0) begin
          report_mismatch($sformatf("result for byte %0h with none pending",
                                    res_i.data_byte));
        end else begin
          want = byte_results_q.pop_front();
          check_field("data_byte", res_i.data_byte, want.data_byte, want.data_byte);
          check_field("byte_role", 8'(res_i.byte_role), 8'(want.byte_role),
                      want.data_byte);
          check_field("frame_done", 8'(res_i.frame_done), 8'(want.frame_done),
                      want.data_byte);
          check_field("frame_valid", 8'(res_i.frame_valid), 8'(want.frame_valid),
                      want.data_byte);
          check_field("frame_overflow", 8'(res_i.frame_overflow),
                      8'(want.frame_overflow), want.data_byte);
          check_field("session_active", 8'(res_i.session_active),
                      8'(want.session_active), want.data_byte);
        end
      end
      mismatches_o  <= fail_cnt;
      outstanding_o <= byte_results_q.size();
    end
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

// Top of the receiver bench: builds a byte stream, pushes it into rx_i with
// random gaps, stalls res_o at random, and reports the verdict. All checking
// lives in sfr_checker.
module tb_top;

  localparam int unsigned HdrBytes    = 7;
  localparam int unsigned MaxBody     = 256;
  localparam int unsigned NumItems    = 1150;
  localparam int unsigned TailItems   = 150;  // no idling on either side here
  localparam int unsigned DrainCycles = 10;   // a result trails its request through the input and result registers
  localparam int unsigned GapChunk    = 64;   // bytes per sender idling mode
  localparam int unsigned StallChunk  = 128;  // sink loop iterations per stall mode

  logic clk_i;
  logic rst_ni;

  sfr_in_if  rx_if ();
  sfr_out_if res_if ();

  int unsigned mismatch_cnt;
  int unsigned pending_cnt;

  logic [7:0] rx_stream_q[$];
  bit         calm_tail;

  serial_frame_receiver_core #(
    .HEADER_BYTES (HdrBytes),
    .MAX_BODY     (MaxBody)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .res_o  (res_if)
  );

  sfr_checker #(
    .HEADER_BYTES (HdrBytes),
    .MAX_BODY     (MaxBody)
  ) u_frame_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rx_i          (rx_if),
    .res_i         (res_if),
    .mismatches_o  (mismatch_cnt),
    .outstanding_o (pending_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Stream builders
  // ---------------------------------------------------------------------------

  // Append one byte to the stream.
  function automatic void add_byte(input logic [7:0] b);
    rx_stream_q = {rx_stream_q, b};
  endfunction

  // First n bytes of the header.
  function automatic void push_header(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) add_byte(sfr_pkg::HeaderPattern[i]);
  endfunction

  // Full frame: header, type, length, random data, checksum. A corrupted
  // checksum is flipped by a nonzero mask so it never matches by accident.
  // With length 255 the body outgrows MAX_BODY on its last data byte; the
  // trailing checksum then just lands on the header matcher.
  function automatic void push_frame(input logic [7:0] kind, input logic [7:0] len,
                                     input bit corrupt);
    logic [7:0] sum;
    logic [7:0] d;
    push_header(HdrBytes);
    add_byte(kind);
    add_byte(len);
    sum = sfr_pkg::SumSeed + kind + len;
    for (int unsigned i = 0; i < len; i++) begin
      d = 8'($urandom_range(0, 255));
      sum += d;
      add_byte(d);
    end
    add_byte(corrupt ? sum ^ 8'($urandom_range(1, 255)) : sum);
  endfunction

  function automatic void build_stream();
    int unsigned pick;
    int unsigned n;
    logic [7:0]  len;

    // Directed: extremes as noise, mismatch with an 'I' restarting the match,
    // a bad frame while the session is still off, then an empty valid frame
    // that turns the session on.
    add_byte(8'h00);
    add_byte(8'hFF);
    push_header(2);
    push_header(HdrBytes);
    add_byte(8'hFF);                                   // type
    add_byte(8'h01);                                   // length
    add_byte(8'hFF);                                   // data
    add_byte(8'(sfr_pkg::SumSeed + 8'hFF + 8'h01));    // checksum off by the data byte
    push_frame(8'h00, 8'h00, 1'b0);

    // Body limit: a frame that overflows, then the longest frame that still fits.
    push_frame(8'($urandom_range(0, 255)), 8'd255, 1'b0);
    push_frame(8'($urandom_range(0, 255)), 8'd254, 1'b0);

    while (rx_stream_q.size() < NumItems) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0, 1, 2, 3, 4, 5: begin
          // well-formed frame, mostly short, some checksums wrong
          len = ($urandom_range(0, 29) == 0) ? 8'($urandom_range(13, 60))
                                             : 8'($urandom_range(0, 12));
          push_frame(8'($urandom_range(0, 255)), len, $urandom_range(0, 3) == 0);
        end
        6, 7: begin
          // header cut short, followed by an 'I' or any byte
          push_header($urandom_range(1, HdrBytes - 1));
          add_byte($urandom_range(0, 1) ? sfr_pkg::HeaderPattern[0]
                                        : 8'($urandom_range(0, 255)));
        end
        8: begin
          n = $urandom_range(1, 4);
          repeat (n) add_byte(8'($urandom_range(0, 255)));
        end
        default: begin
          // truncated body: what follows is swallowed as data of this frame
          push_header(HdrBytes);
          add_byte(8'($urandom_range(0, 255)));
          len = 8'($urandom_range(3, 20));
          add_byte(len);
          n = $urandom_range(0, len - 1);
          repeat (n) add_byte(8'($urandom_range(0, 255)));
        end
      endcase
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned gap_pct;
    rst_ni        <= 1'b0;
    rx_if.valid   <= 1'b0;
    rx_if.rx_byte <= '0;
    calm_tail     = 1'b0;
    gap_pct       = 0;
    build_stream();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int unsigned idx = 0; idx < rx_stream_q.size(); idx++) begin
      // idling density changes every chunk; zero gives bursts with no gaps
      if (idx % GapChunk == 0) begin
        case ($urandom_range(0, 2))
          0:       gap_pct = 0;
          1:       gap_pct = 10;
          default: gap_pct = 35;
        endcase
      end
      calm_tail = (idx + TailItems >= rx_stream_q.size());
      if (!calm_tail && $urandom_range(0, 99) < gap_pct) begin
        rx_if.valid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
      rx_if.valid   <= 1'b1;
      rx_if.rx_byte <= rx_stream_q[idx];
      do @(posedge clk_i); while (!rx_if.ready);
    end
    rx_if.valid <= 1'b0;

    // let the checker see the last request before polling its count
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts, density changing over time
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned stall_pct;
    int unsigned tick;
    res_if.ready <= 1'b1;
    stall_pct    = 0;
    tick         = 0;
    forever begin
      @(posedge clk_i);
      if (tick % StallChunk == 0) begin
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 5;
          default: stall_pct = 25;
        endcase
      end
      tick++;
      if (!calm_tail && $urandom_range(0, 99) < stall_pct) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
        res_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: about ten times the slowest legal run.
  initial begin
    #500000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
